@@ hdl/spq_pkg.sv @@
`default_nettype none
package spq_pkg;

  typedef enum logic [1:0] {
    CMD_ENQ  = 2'd0,
    CMD_DEQ  = 2'd1,
    CMD_PEEK = 2'd2
  } spq_cmd_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } spq_status_t;

  typedef struct packed {
    logic signed [31:0] data;
    logic signed [31:0] prio;
  } spq_entry_t;

  // broadcast to every cell
  typedef struct packed {
    logic       enq;
    logic       deq;
    spq_entry_t new_entry;
  } spq_ctrl_t;

endpackage
`default_nettype wire

@@ hdl/sorted_priority_queue_unit.sv @@
`default_nettype none
// Sorted min-priority queue of CAPACITY entries. Each input beat carries a
// command in s_tuser (enqueue, dequeue, peek) with payload and priority in
// s_tdata; each accepted beat gives exactly one result beat carrying the
// front entry (dequeue or peek), a status in m_tuser (ok, empty, full) and
// the occupancy after the operation, truncated to five bits. Entries sit in
// a row of cells kept in ascending signed priority, front at cell 0; an
// enqueue goes ahead of all entries of equal or greater priority, so the
// newest of equal priorities is served first. In every operation all cells
// compare against the new priority and shift left, right or load in the
// same cycle, so a new beat is taken every cycle as long as the result
// register is empty or is being drained in that cycle. The result appears in
// the cycle after acceptance. Full enqueue and empty dequeue/peek only report
// status; code 3 is a no-op reporting ok with zero payload.
module sorted_priority_queue_unit
  import spq_pkg::*;
#(
  parameter int CAPACITY = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [63:0] s_tdata,   // [31:0] data_in, [63:32] priority_in
  input  wire logic [1:0]  s_tuser,   // [1:0] command
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [71:0]      m_tdata,   // [31:0] data_out, [63:32] priority_out,
                                      // [68:64] occupancy, rest zero
  output logic [1:0]       m_tuser    // [1:0] status
);

  localparam int CW = $clog2(CAPACITY + 1);

  logic [CW-1:0] count;
  logic [CW-1:0] count_next;
  logic          accept;
  logic          full;
  logic          empty;
  spq_cmd_t      cmd;
  spq_ctrl_t     ctrl;

  spq_entry_t    cells [CAPACITY];
  logic          ge    [CAPACITY];
  logic          occ   [CAPACITY];

  spq_status_t   status;
  spq_entry_t    front_out;

  // output register frees itself when drained
  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;
  assign cmd      = spq_cmd_t'(s_tuser);
  assign full     = (count == CW'(CAPACITY));
  assign empty    = (count == '0);

  assign ctrl.enq            = accept && (cmd == CMD_ENQ) && !full;
  assign ctrl.deq            = accept && (cmd == CMD_DEQ) && !empty;
  assign ctrl.new_entry.data = s_tdata[31:0];
  assign ctrl.new_entry.prio = s_tdata[63:32];

  // row of cells; cell 0 is the front
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    assign occ[i] = (count > CW'(i));
    spq_cell u_cell (
      .clk         (clk),
      .ctrl        (ctrl),
      .occ         (occ[i]),
      .ge_left     ((i == 0) ? 1'b0 : ge[(i == 0) ? 0 : i - 1]),
      .left_entry  ((i == 0) ? ctrl.new_entry : cells[(i == 0) ? 0 : i - 1]),
      .right_entry ((i == CAPACITY - 1) ? cells[i]
                                        : cells[(i == CAPACITY - 1) ? i : i + 1]),
      .ge          (ge[i]),
      .entry       (cells[i])
    );
  end

  always_comb begin
    count_next = count;
    if (ctrl.enq) begin
      count_next = count + 1'b1;
    end else if (ctrl.deq) begin
      count_next = count - 1'b1;
    end
  end

  // result of the current beat
  always_comb begin
    status    = ST_OK;
    front_out = '0;
    case (cmd)
      CMD_ENQ: begin
        if (full) status = ST_FULL;
      end
      CMD_DEQ, CMD_PEEK: begin
        if (empty) begin
          status = ST_EMPTY;
        end else begin
          front_out = cells[0];
        end
      end
      default: begin
        status = ST_OK;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      count <= count_next;
      if (accept) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk) begin
    if (accept) begin
      m_tdata <= {3'b000, 5'(count_next), front_out.prio, front_out.data};
      m_tuser <= status;
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(CAPACITY))
    else $error("entry count above capacity");

  a_enq_grows: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tuser == CMD_ENQ && count != CW'(CAPACITY)
    |=> count == $past(count) + 1'b1)
    else $error("enqueue did not grow the queue");

  a_full_occ: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == ST_FULL |-> m_tdata[68:64] == 5'(CAPACITY))
    else $error("full status with wrong occupancy");

  a_empty_occ: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == ST_EMPTY |-> m_tdata[68:64] == 5'd0)
    else $error("empty status with non-zero occupancy");
`endif

endmodule
`default_nettype wire

@@ hdl/spq_cell.sv @@
`default_nettype none
module spq_cell
  import spq_pkg::*;
(
  input  wire logic       clk,
  input  wire spq_ctrl_t  ctrl,
  input  wire logic       occ,       // this slot holds a live entry
  input  wire logic       ge_left,   // left neighbour moves right on insert
  input  wire spq_entry_t left_entry,
  input  wire spq_entry_t right_entry,
  output logic            ge,
  output spq_entry_t      entry
);

  spq_entry_t entry_next;

  // slot is at or beyond the insertion point
  assign ge = !occ || ($signed(entry.prio) >= $signed(ctrl.new_entry.prio));

  always_comb begin
    entry_next = entry;
    if (ctrl.enq) begin
      if (ge && ge_left) begin
        entry_next = left_entry;
      end else if (ge) begin
        entry_next = ctrl.new_entry;
      end
    end else if (ctrl.deq) begin
      entry_next = right_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry <= entry_next;
  end

endmodule
`default_nettype wire

@@ bench/sorted_priority_queue_unit_tb.sv @@
`timescale 1ns / 1ps
module sorted_priority_queue_unit_tb;
  import spq_pkg::*;

  localparam int CAPACITY = 16;
  localparam int RANDOM_ITEMS = 700;
  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 10;
  // command code 3 is not in the package enum; the block treats it as a no-op
  localparam logic [1:0] CMD_NOP = 2'd3;
  localparam logic [31:0] P_MIN = 32'h8000_0000;
  localparam logic [31:0] P_MAX = 32'h7fff_ffff;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [31:0] data;
    logic [31:0] prio;
  } queue_op_t;

  typedef struct packed {
    logic [31:0] data;
    logic [31:0] prio;
    logic [1:0]  status;
    logic [4:0]  occ;
  } queue_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic [63:0] s_tdata = '0;   // [31:0] data_in, [63:32] priority_in
  logic [1:0]  s_tuser = '0;   // [1:0] command
  logic        m_tready = 1'b0;
  wire         s_tready;
  wire         m_tvalid;
  wire  [71:0] m_tdata;        // [31:0] data_out, [63:32] priority_out, [68:64] occupancy
  wire  [1:0]  m_tuser;        // [1:0] status

  sorted_priority_queue_unit #(.CAPACITY(CAPACITY)) dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  queue_op_t     pending_ops[$];
  queue_result_t expected_results[$];
  int            failures = 0;
  int            cycles = 0;
  logic          in_beat = 1'b0;   // input beat taken at the last rising edge

  // shadow copy of the sorted entries, front at index 0
  logic signed [31:0] shadow_data [CAPACITY];
  logic signed [31:0] shadow_prio [CAPACITY];
  int                 shadow_count = 0;

  // sender burst/gap and receiver stall pattern
  int         burst_left = 0;
  int         gap_left = 0;
  logic [7:0] ready_pat = 8'hff;
  logic [2:0] ready_phase = '0;
  int         pat_age = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  // apply one command to the shadow queue and return the result beat it gives
  function automatic queue_result_t apply_to_shadow(queue_op_t op);
    queue_result_t r;
    int pos;
    r = '0;
    case (op.cmd)
      CMD_ENQ: begin
        if (shadow_count >= CAPACITY) begin
          r.status = ST_FULL;
        end else begin
          // goes ahead of every entry of equal or greater priority
          pos = 0;
          while (pos < shadow_count && shadow_prio[pos] < $signed(op.prio)) pos++;
          for (int i = shadow_count; i > pos; i--) begin
            shadow_data[i] = shadow_data[i-1];
            shadow_prio[i] = shadow_prio[i-1];
          end
          shadow_data[pos] = op.data;
          shadow_prio[pos] = op.prio;
          shadow_count++;
        end
      end
      CMD_DEQ, CMD_PEEK: begin
        if (shadow_count == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.data = shadow_data[0];
          r.prio = shadow_prio[0];
          if (op.cmd == CMD_DEQ) begin
            for (int i = 1; i < shadow_count; i++) begin
              shadow_data[i-1] = shadow_data[i];
              shadow_prio[i-1] = shadow_prio[i];
            end
            shadow_count--;
          end
        end
      end
      default: ;
    endcase
    r.occ = 5'(shadow_count);
    return r;
  endfunction

  task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] got_v);
    if (exp_v !== got_v) begin
      $display("%0t: %s mismatch: expected %h, actual %h", $time, name, exp_v, got_v);
      failures++;
    end
  endtask

  task automatic add_op(logic [1:0] cmd, logic [31:0] data, logic [31:0] prio);
    queue_op_t op;
    op.cmd = cmd;
    op.data = data;
    op.prio = prio;
    pending_ops.push_back(op);
  endtask

  // mostly narrow ranges so that ties and equal keys turn up often
  function automatic logic [31:0] pick_priority();
    int r;
    r = $urandom_range(99);
    if (r < 40) return 32'($signed($urandom_range(8)) - 4);
    if (r < 70) return 32'($signed($urandom_range(200)) - 100);
    if (r < 90) return $urandom;
    case ($urandom_range(3))
      0: return P_MIN;
      1: return P_MAX;
      2: return 32'h0;
      default: return 32'hffff_ffff;
    endcase
  endfunction

  // prediction and checking, both on the rising edge
  always @(posedge clk) begin : monitor
    queue_op_t     taken;
    queue_result_t exp_r;
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("sorted_priority_queue_unit_tb NOT OK");
      $finish;
    end else if (rst) begin
      in_beat <= 1'b0;
      shadow_count = 0;
    end else begin
      in_beat <= s_tvalid && s_tready;
      if (s_tvalid && s_tready) begin
        taken.cmd = s_tuser;
        taken.data = s_tdata[31:0];
        taken.prio = s_tdata[63:32];
        expected_results.push_back(apply_to_shadow(taken));
      end
      if (m_tvalid && m_tready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result beat: expected none, actual %h/%h", $time,
                   m_tdata, m_tuser);
          failures++;
        end else begin
          exp_r = expected_results.pop_front();
          check_field("data_out", exp_r.data, m_tdata[31:0]);
          check_field("priority_out", exp_r.prio, m_tdata[63:32]);
          check_field("status", 32'(exp_r.status), 32'(m_tuser));
          check_field("occupancy", 32'(exp_r.occ), 32'(m_tdata[68:64]));
        end
      end
    end
  end

  // driver and receiver stalls, on the falling edge
  always @(negedge clk) begin : driver
    logic next_valid;
    next_valid = 1'b0;
    if (!rst) begin
      if (in_beat) void'(pending_ops.pop_front());
      if (s_tvalid && !in_beat) begin
        next_valid = 1'b1;   // beat still waiting, hold it
      end else if (gap_left > 0) begin
        gap_left--;
      end else if (pending_ops.size() > 0) begin
        next_valid = 1'b1;
        if (burst_left <= 1) begin
          burst_left = $urandom_range(24, 1);
          gap_left = ($urandom_range(3) == 0) ? 0 : $urandom_range(6, 1);
        end else begin
          burst_left--;
        end
      end
    end
    s_tvalid <= next_valid;
    if (next_valid) begin
      s_tuser <= pending_ops[0].cmd;
      s_tdata <= {pending_ops[0].prio, pending_ops[0].data};
    end

    // receiver: a rotating 8-bit ready pattern, swapped every so often
    pat_age++;
    if (pat_age >= 97) begin
      pat_age = 0;
      ready_pat = ($urandom_range(3) == 0) ? 8'hff : 8'($urandom);
      if (ready_pat == 8'h00) ready_pat = 8'h01;
    end
    ready_phase = ready_phase + 3'd1;
    m_tready <= ready_pat[ready_phase];
  end

  initial begin : stimulus
    int made;
    int chunk;
    int enq_w;
    int r;
    logic [1:0] cmd;
    made = 0;

    // directed: empty cases, no-op, extremes and ties, fill to full, full enqueue
    add_op(CMD_PEEK, 32'hffff_ffff, 32'hffff_ffff);
    add_op(CMD_DEQ, 32'hffff_ffff, 32'hffff_ffff);
    add_op(CMD_NOP, 32'hffff_ffff, 32'hffff_ffff);
    add_op(CMD_ENQ, 32'h7fff_ffff, P_MAX);
    add_op(CMD_ENQ, 32'h8000_0000, P_MIN);
    add_op(CMD_ENQ, 32'h0, 32'h0);
    add_op(CMD_ENQ, 32'hffff_ffff, 32'hffff_ffff);
    add_op(CMD_ENQ, 32'd5, 32'h0);
    add_op(CMD_ENQ, 32'd6, 32'h0);
    add_op(CMD_ENQ, 32'd7, P_MAX);
    add_op(CMD_ENQ, 32'd8, P_MIN);
    for (int i = 0; i < 8; i++) add_op(CMD_ENQ, $urandom, 32'(i * 3 - 10));
    add_op(CMD_ENQ, 32'hdead_beef, 32'h0);
    add_op(CMD_NOP, 32'h0, 32'h0);
    add_op(CMD_PEEK, 32'h0, 32'h0);
    for (int i = 0; i < 3; i++) add_op(CMD_DEQ, 32'h0, 32'h0);

    // random: chunks with a bias towards filling, draining or balance
    while (made < RANDOM_ITEMS) begin
      chunk = $urandom_range(80, 30);
      case ($urandom_range(4))
        0: enq_w = 15;
        1: enq_w = 45;
        2: enq_w = 50;
        3: enq_w = 55;
        default: enq_w = 85;
      endcase
      for (int i = 0; i < chunk; i++) begin
        r = $urandom_range(99);
        if (r < enq_w) cmd = CMD_ENQ;
        else if (r >= 97) cmd = CMD_NOP;
        else cmd = ($urandom_range(2) == 0) ? CMD_PEEK : CMD_DEQ;
        add_op(cmd, $urandom, pick_priority());
        if (cmd != CMD_NOP) made++;
      end
    end

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (pending_ops.size() != 0 || expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (failures == 0) begin
      $display("sorted_priority_queue_unit_tb OK");
    end else begin
      $display("sorted_priority_queue_unit_tb NOT OK");
    end
    $finish;
  end

endmodule

@@ sim.f @@
hdl/spq_pkg.sv
hdl/spq_cell.sv
hdl/sorted_priority_queue_unit.sv
bench/sorted_priority_queue_unit_tb.sv
